@@ rtl/oef_pkg.sv @@
// oef_pkg: shared constants, micro-op codes and controller/datapath structs
// for the one-euro filter; no dependencies
package oef_pkg;

    localparam int AXES = 3;
    localparam int AXW = 2;
    localparam int SW = 32;
    localparam int CW = 23;
    localparam int AW = 31;

    localparam logic [1:0] CFG_BASE_CUTOFF = 2'd0;
    localparam logic [1:0] CFG_BETA = 2'd1;
    localparam logic [1:0] CFG_DERIV_CUTOFF = 2'd2;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    localparam logic [63:0] TAU_SCALE = 64'd10430378350;
    localparam logic [32:0] US_PER_S = 33'd1000000;
    localparam logic [65:0] PROD_CAP = 66'h1 << 62;
    localparam logic [65:0] ROUND_HALF = 66'h1 << 29;

    localparam logic [4:0] OP_NONE = 5'd0;
    localparam logic [4:0] OP_INIT = 5'd1;
    localparam logic [4:0] OP_DT = 5'd2;
    localparam logic [4:0] OP_MUL_DP = 5'd3;
    localparam logic [4:0] OP_MUL_AP = 5'd4;
    localparam logic [4:0] OP_P_LOAD = 5'd5;
    localparam logic [4:0] OP_NORM = 5'd6;
    localparam logic [4:0] OP_DIV_ALPHA = 5'd7;
    localparam logic [4:0] OP_AD_SET = 5'd8;
    localparam logic [4:0] OP_A_SET = 5'd9;
    localparam logic [4:0] OP_MUL_RATE = 5'd10;
    localparam logic [4:0] OP_DIV_RATE = 5'd11;
    localparam logic [4:0] OP_RATE_SET = 5'd12;
    localparam logic [4:0] OP_MUL_SB = 5'd13;
    localparam logic [4:0] OP_SB_SET = 5'd14;
    localparam logic [4:0] OP_MUL_CUT = 5'd15;
    localparam logic [4:0] OP_CUT_SET = 5'd16;
    localparam logic [4:0] OP_MUL_Y = 5'd17;
    localparam logic [4:0] OP_Y_SET = 5'd18;
    localparam logic [4:0] OP_OUT = 5'd19;

    typedef struct packed {
        logic           capture;
        logic [4:0]     op;
        logic [AXW-1:0] axis;
    } oef_cmd_t;

    typedef struct packed {
        logic init_req;
        logic s_big;
        logic div_busy;
        logic out_full;
    } oef_stat_t;

endpackage

@@ rtl/oef_div.sv @@
// oef_div: radix-2 restoring divider, 64-bit dividend by 33-bit divisor,
// one quotient bit per cycle; depends on nothing
module oef_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [32:0] divisor,
    output logic        busy,
    output logic [63:0] quot
);

    logic        busy_reg, busy_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] dvd_reg, dvd_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] dsr_reg, dsr_next;
    logic [33:0] rem_sh;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        rem_sh = {rem_reg[32:0], dvd_reg[63]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = 7'd64;
            dvd_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sh - {1'b0, dsr_reg};
                dvd_next = {dvd_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                dvd_next = {dvd_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = busy_reg;
    assign quot = dvd_reg;

endmodule

@@ rtl/oef_dp.sv @@
// oef_dp: filter datapath with state, config registers, shared multiplier
// and output register; depends on oef_pkg and oef_div
module oef_dp
    import oef_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  oef_cmd_t        cmd_bus,
    output oef_stat_t       stat,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [CW-1:0]   cfg_data,
    input  logic            cmd,
    input  logic [SW-1:0]   x0,
    input  logic [SW-1:0]   x1,
    input  logic [SW-1:0]   x2,
    input  logic [31:0]     time_us,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [SW-1:0]   y0,
    output logic [SW-1:0]   y1,
    output logic [SW-1:0]   y2
);

    logic [CW-1:0] base_cutoff_reg, beta_reg, deriv_cutoff_reg;
    logic          primed_reg, out_valid_reg, restart_reg;
    logic [SW-1:0] last_out_reg [AXES];
    logic [SW-1:0] srate_reg [AXES];
    logic [SW-1:0] x_reg [AXES];
    logic [SW-1:0] y_reg [AXES];
    logic [31:0]   last_time_reg, time_reg, dt_reg;
    logic [65:0]   prod_reg;
    logic          neg_reg;
    logic [62:0]   p_reg;
    logic [63:0]   s_reg;
    logic [AW-1:0] ad_reg, a_reg;
    logic [SW-1:0] rate_reg;
    logic [31:0]   cutoff_reg;

    logic [SW-1:0] ax_x, ax_lo, ax_sr;
    logic [32:0]   d_y, d_sb, mag_y, mag_sb, mag_sr, ma, mb;
    logic          neg_sel;
    logic [31:0]   diff_t, dt_new;
    logic          div_start, div_busy;
    logic [63:0]   div_dvd, div_quot;
    logic [32:0]   div_dsr;
    logic [32:0]   lim, rate_v;
    logic [SW-1:0] rate_new;
    logic [65:0]   rnd_sum;
    logic [33:0]   rnd_q, blend_sb, blend_y;
    logic [49:0]   cut_sum;
    logic [62:0]   p_new;

    function automatic logic [32:0] abs33(input logic [32:0] v);
        abs33 = v[32] ? (~v + 33'd1) : v;
    endfunction

    assign ax_x = x_reg[cmd_bus.axis];
    assign ax_lo = last_out_reg[cmd_bus.axis];
    assign ax_sr = srate_reg[cmd_bus.axis];
    assign d_y = {ax_x[SW-1], ax_x} - {ax_lo[SW-1], ax_lo};
    assign d_sb = {rate_reg[SW-1], rate_reg} - {ax_sr[SW-1], ax_sr};
    assign mag_y = abs33(d_y);
    assign mag_sb = abs33(d_sb);
    assign mag_sr = abs33({ax_sr[SW-1], ax_sr});

    always_comb
    begin
        ma = '0;
        mb = '0;
        neg_sel = neg_reg;
        unique case (cmd_bus.op)
            OP_MUL_RATE:
            begin
                ma = mag_y;
                mb = US_PER_S;
                neg_sel = d_y[32];
            end
            OP_MUL_SB:
            begin
                ma = mag_sb;
                mb = {2'b0, ad_reg};
                neg_sel = d_sb[32];
            end
            OP_MUL_Y:
            begin
                ma = mag_y;
                mb = {2'b0, a_reg};
                neg_sel = d_y[32];
            end
            OP_MUL_DP:
            begin
                ma = {10'b0, deriv_cutoff_reg};
                mb = {1'b0, dt_reg};
            end
            OP_MUL_CUT:
            begin
                ma = {10'b0, beta_reg};
                mb = mag_sr;
            end
            OP_MUL_AP:
            begin
                ma = {1'b0, cutoff_reg};
                mb = {1'b0, dt_reg};
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign diff_t = time_reg - last_time_reg;
    assign dt_new = (diff_t == 32'd0) ? 32'd1 : diff_t;

    assign lim = neg_reg ? 33'h080000000 : 33'h07FFFFFFF;
    assign rate_v = (div_quot > {31'b0, lim}) ? lim : div_quot[32:0];
    assign rate_new = neg_reg ? (~rate_v[SW-1:0] + 32'd1) : rate_v[SW-1:0];

    assign rnd_sum = prod_reg + ROUND_HALF;
    assign rnd_q = rnd_sum[63:30];
    assign blend_sb = neg_reg ? ({{2{ax_sr[SW-1]}}, ax_sr} - rnd_q)
                              : ({{2{ax_sr[SW-1]}}, ax_sr} + rnd_q);
    assign blend_y = neg_reg ? ({{2{ax_lo[SW-1]}}, ax_lo} - rnd_q)
                             : ({{2{ax_lo[SW-1]}}, ax_lo} + rnd_q);

    assign cut_sum = prod_reg[65:16] + {27'b0, base_cutoff_reg};
    assign p_new = (prod_reg > PROD_CAP) ? PROD_CAP[62:0] : prod_reg[62:0];

    assign div_start = (cmd_bus.op == OP_DIV_ALPHA) || (cmd_bus.op == OP_DIV_RATE);
    assign div_dvd = (cmd_bus.op == OP_DIV_ALPHA) ? {1'b0, p_reg[32:0], 30'b0}
                                                  : prod_reg[63:0];
    assign div_dsr = (cmd_bus.op == OP_DIV_ALPHA) ? s_reg[32:0] : {1'b0, dt_reg};

    oef_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cutoff_reg <= CW'(65536);
            beta_reg <= '0;
            deriv_cutoff_reg <= CW'(65536);
            primed_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            last_time_reg <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                last_out_reg[i] <= '0;
                srate_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE_CUTOFF: base_cutoff_reg <= cfg_data;
                    CFG_BETA: beta_reg <= cfg_data;
                    CFG_DERIV_CUTOFF: deriv_cutoff_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd_bus.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd_bus.op)
                OP_INIT:
                begin
                    primed_reg <= 1'b1;
                    last_time_reg <= time_reg;
                    for (int i = 0; i < AXES; i++)
                    begin
                        last_out_reg[i] <= x_reg[i];
                        srate_reg[i] <= '0;
                    end
                end
                OP_DT: last_time_reg <= time_reg;
                OP_SB_SET: srate_reg[cmd_bus.axis] <= blend_sb[SW-1:0];
                OP_Y_SET: last_out_reg[cmd_bus.axis] <= blend_y[SW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_bus.capture)
        begin
            restart_reg <= cmd;
            time_reg <= time_us;
            x_reg[0] <= x0;
            x_reg[1] <= x1;
            x_reg[2] <= x2;
        end
        if ((cmd_bus.op == OP_MUL_RATE) || (cmd_bus.op == OP_MUL_SB) ||
            (cmd_bus.op == OP_MUL_Y) || (cmd_bus.op == OP_MUL_DP) ||
            (cmd_bus.op == OP_MUL_CUT) || (cmd_bus.op == OP_MUL_AP))
        begin
            prod_reg <= ma * mb;
            neg_reg <= neg_sel;
        end
        case (cmd_bus.op)
            OP_DT: dt_reg <= dt_new;
            OP_P_LOAD:
            begin
                p_reg <= p_new;
                s_reg <= {1'b0, p_new} + TAU_SCALE;
            end
            OP_NORM:
            begin
                p_reg <= p_reg >> 1;
                s_reg <= s_reg >> 1;
            end
            OP_AD_SET: ad_reg <= div_quot[AW-1:0];
            OP_A_SET: a_reg <= div_quot[AW-1:0];
            OP_RATE_SET: rate_reg <= rate_new;
            OP_CUT_SET: cutoff_reg <= (cut_sum[49:32] != '0) ? '1 : cut_sum[31:0];
            OP_OUT:
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    y_reg[i] <= last_out_reg[i];
                end
            end
            default: ;
        endcase
    end

    assign stat.init_req = (restart_reg == CMD_RESTART) || !primed_reg;
    assign stat.s_big = (s_reg[63:33] != '0);
    assign stat.div_busy = div_busy;
    assign stat.out_full = out_valid_reg && out_stall;

    assign out_valid = out_valid_reg;
    assign y0 = y_reg[0];
    assign y1 = y_reg[1];
    assign y2 = y_reg[2];

endmodule

@@ rtl/oef_ctrl.sv @@
// oef_ctrl: sequencer that steps the datapath through one request
// depends on oef_pkg
module oef_ctrl
    import oef_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  oef_stat_t stat,
    output oef_cmd_t  cmd_bus
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CHECK = 5'd1;
    localparam logic [4:0] S_MUL_DP = 5'd2;
    localparam logic [4:0] S_P_LOAD = 5'd3;
    localparam logic [4:0] S_NORM = 5'd4;
    localparam logic [4:0] S_A_WAIT = 5'd5;
    localparam logic [4:0] S_R_MUL = 5'd6;
    localparam logic [4:0] S_R_DIV = 5'd7;
    localparam logic [4:0] S_R_WAIT = 5'd8;
    localparam logic [4:0] S_SB_MUL = 5'd9;
    localparam logic [4:0] S_SB_SET = 5'd10;
    localparam logic [4:0] S_C_MUL = 5'd11;
    localparam logic [4:0] S_C_SET = 5'd12;
    localparam logic [4:0] S_AP_MUL = 5'd13;
    localparam logic [4:0] S_Y_MUL = 5'd14;
    localparam logic [4:0] S_Y_SET = 5'd15;
    localparam logic [4:0] S_OUT = 5'd16;

    localparam logic [AXW-1:0] LAST_AXIS = AXW'(AXES - 1);

    logic [4:0]     state_reg, state_next;
    logic [AXW-1:0] axis_reg, axis_next;
    logic           phase_reg, phase_next;
    logic [4:0]     op;

    always_comb
    begin
        state_next = state_reg;
        axis_next = axis_reg;
        phase_next = phase_reg;
        op = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.init_req)
                begin
                    op = OP_INIT;
                    state_next = S_OUT;
                end
                else
                begin
                    op = OP_DT;
                    state_next = S_MUL_DP;
                end
            end
            S_MUL_DP:
            begin
                op = OP_MUL_DP;
                phase_next = 1'b0;
                state_next = S_P_LOAD;
            end
            S_P_LOAD:
            begin
                op = OP_P_LOAD;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (stat.s_big)
                begin
                    op = OP_NORM;
                end
                else
                begin
                    op = OP_DIV_ALPHA;
                    state_next = S_A_WAIT;
                end
            end
            S_A_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    if (phase_reg)
                    begin
                        op = OP_A_SET;
                        state_next = S_Y_MUL;
                    end
                    else
                    begin
                        op = OP_AD_SET;
                        axis_next = '0;
                        state_next = S_R_MUL;
                    end
                end
            end
            S_R_MUL:
            begin
                op = OP_MUL_RATE;
                state_next = S_R_DIV;
            end
            S_R_DIV:
            begin
                op = OP_DIV_RATE;
                state_next = S_R_WAIT;
            end
            S_R_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    op = OP_RATE_SET;
                    state_next = S_SB_MUL;
                end
            end
            S_SB_MUL:
            begin
                op = OP_MUL_SB;
                state_next = S_SB_SET;
            end
            S_SB_SET:
            begin
                op = OP_SB_SET;
                if (axis_reg == LAST_AXIS)
                begin
                    axis_next = '0;
                    state_next = S_C_MUL;
                end
                else
                begin
                    axis_next = axis_reg + AXW'(1);
                    state_next = S_R_MUL;
                end
            end
            S_C_MUL:
            begin
                op = OP_MUL_CUT;
                state_next = S_C_SET;
            end
            S_C_SET:
            begin
                op = OP_CUT_SET;
                state_next = S_AP_MUL;
            end
            S_AP_MUL:
            begin
                op = OP_MUL_AP;
                phase_next = 1'b1;
                state_next = S_P_LOAD;
            end
            S_Y_MUL:
            begin
                op = OP_MUL_Y;
                state_next = S_Y_SET;
            end
            S_Y_SET:
            begin
                op = OP_Y_SET;
                if (axis_reg == LAST_AXIS)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    axis_next = axis_reg + AXW'(1);
                    state_next = S_C_MUL;
                end
            end
            S_OUT:
            begin
                if (!stat.out_full)
                begin
                    op = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg <= axis_next;
            phase_reg <= phase_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign cmd_bus.capture = (state_reg == S_IDLE) && in_valid;
    assign cmd_bus.op = op;
    assign cmd_bus.axis = axis_reg;

endmodule

@@ rtl/one_euro_filter.sv @@
// one_euro_filter: top level of the three-axis adaptive low-pass filter
// depends on oef_pkg, oef_ctrl and oef_dp
//
// Requests enter on in_valid/in_stall with cmd, x0..x2 (signed Q16.16) and
// time_us; each request gives one result on out_valid/out_stall as y0..y2.
// A request is taken when in_valid is high and in_stall low. Registers
// base_cutoff, beta and deriv_cutoff (index 0..2) are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the filter is
// idle, as the block does not enforce it. A restart request, or the first
// after reset, loads the filter state from its samples and gives them as
// its result. A filter request runs seven divisions on one shared 64-step
// serial divider plus 1 to 30 normalizing shifts for each of its four
// alphas. One request is in flight at a time; the next can be taken in the
// cycle after the result is written. Results sit in an output register;
// the next request is taken while a result still waits, and the block only
// holds before writing a new result while out_stall keeps the old one in
// place. Reset clears the filter state and loads the register defaults.
module one_euro_filter
    import oef_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [CW-1:0] cfg_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          cmd,
    input  logic [SW-1:0] x0,
    input  logic [SW-1:0] x1,
    input  logic [SW-1:0] x2,
    input  logic [31:0]   time_us,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [SW-1:0] y0,
    output logic [SW-1:0] y1,
    output logic [SW-1:0] y2
);

    oef_cmd_t  cmd_bus;
    oef_stat_t stat;

    oef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd_bus  (cmd_bus)
    );

    oef_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_bus   (cmd_bus),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .x0        (x0),
        .x1        (x1),
        .x2        (x2),
        .time_us   (time_us),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .y0        (y0),
        .y1        (y1),
        .y2        (y2)
    );

endmodule
